FILE: hdl/ggb_pkg.sv
// Shared types, constants and register codes for the gray 3x3 blur block.
package ggb_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int PIX_W       = 8;
	localparam int WIDTH_CFG_W = 11;
	localparam int WEIGHT_W    = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int POS_W       = 10;

	// Luma weights 0.299, 0.587 and 0.114 in unsigned Q0.16.
	localparam logic [WEIGHT_W-1:0] LUMA_R = 16'd19595;
	localparam logic [WEIGHT_W-1:0] LUMA_G = 16'd38470;
	localparam logic [WEIGHT_W-1:0] LUMA_B = 16'd7471;

	localparam logic [POS_W-1:0] ROW_LIMIT = 10'd1023;

	localparam logic [WIDTH_CFG_W-1:0] IMAGE_WIDTH_RST   = 11'd512;
	localparam logic [WEIGHT_W-1:0]    WEIGHT_CENTER_RST = 16'd9684;
	localparam logic [WEIGHT_W-1:0]    WEIGHT_EDGE_RST   = 16'd7754;
	localparam logic [WEIGHT_W-1:0]    WEIGHT_CORNER_RST = 16'd6209;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_WEIGHT_CENTER = 2'd1,
		CFG_WEIGHT_EDGE   = 2'd2,
		CFG_WEIGHT_CORNER = 2'd3
	} ggb_cfg_idx_t;

	typedef struct packed {
		logic [WIDTH_CFG_W-1:0] image_width;
		logic [WEIGHT_W-1:0]    weight_center;
		logic [WEIGHT_W-1:0]    weight_edge;
		logic [WEIGHT_W-1:0]    weight_corner;
	} ggb_cfg_t;

	// One classified pixel on its way from the front to the back.
	typedef struct packed {
		logic [PIX_W-1:0] gray;
		logic [POS_W-1:0] out_row;
		logic             emit;
	} ggb_pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] blurred;
		logic [POS_W-1:0] out_column;
		logic [POS_W-1:0] out_row;
	} ggb_res_t;

endpackage

FILE: hdl/ggb_fifo.sv
// Small register queue with occupancy count, used between the block's parts.
module ggb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rd_data,
	output logic                         valid,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = slot_q[rd_ptr_q];
	assign valid   = (count_q != '0);
	assign count   = count_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNTW'(DEPTH)) || pop)
		else $error("queue written while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count beyond its depth");

endmodule

FILE: hdl/ggb_front.sv
// Front part: accepts pixels, tracks row and column, converts to gray.
module ggb_front #(
	parameter int MAX_WIDTH = ggb_pkg::MAX_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ggb_pkg::ggb_cfg_t                        cfg,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [ggb_pkg::PIX_W-1:0]                red,
	input  logic [ggb_pkg::PIX_W-1:0]                green,
	input  logic [ggb_pkg::PIX_W-1:0]                blue,
	input  logic                                     frame_start,
	input  logic [$clog2(ggb_pkg::MID_DEPTH+1)-1:0]  q_count,
	output logic                                     push,
	output logic [$clog2(MAX_WIDTH)-1:0]             push_col,
	output ggb_pkg::ggb_pix_t                        push_item
);

	import ggb_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int EW_CFG = WIDTH_CFG_W;
	localparam int EW_MAX = $clog2(MAX_WIDTH + 1);
	localparam int EW     = (EW_MAX > EW_CFG) ? EW_MAX : EW_CFG;
	localparam int QCW    = $clog2(MID_DEPTH + 1);
	localparam int PRW    = PIX_W + WEIGHT_W;

	logic [CW-1:0]    col_q;
	logic [POS_W-1:0] row_q;

	logic [EW-1:0]    width_raw;
	logic [EW-1:0]    width_eff;
	logic [CW-1:0]    col_pre;
	logic [CW-1:0]    col_cur;
	logic [CW-1:0]    col_nxt;
	logic [EW-1:0]    col_inc;
	logic [POS_W-1:0] row_pre;
	logic [POS_W-1:0] row_cur;
	logic [POS_W-1:0] row_nxt;
	logic             wrap_pre;
	logic             wrap_post;
	logic             emit;
	logic             accept;
	logic [QCW:0]     load;

	logic             v_s1;
	logic [PIX_W-1:0] r_s1;
	logic [PIX_W-1:0] g_s1;
	logic [PIX_W-1:0] b_s1;
	logic [CW-1:0]    col_s1;
	logic [POS_W-1:0] row_s1;
	logic             emit_s1;

	logic             v_s2;
	logic [PRW-1:0]   pr_s2;
	logic [PRW-1:0]   pg_s2;
	logic [PRW-1:0]   pb_s2;
	logic [CW-1:0]    col_s2;
	logic [POS_W-1:0] row_s2;
	logic             emit_s2;
	logic [PRW:0]     gray_sum;

	// Words in flight count against the queue so the front never overruns it.
	always_comb begin
		load     = (QCW+1)'(q_count) + (QCW+1)'(v_s1) + (QCW+1)'(v_s2);
		in_stall = (load >= (QCW+1)'(MID_DEPTH));
		accept   = in_valid && !in_stall;
	end

	// A column left beyond a narrowed width wraps to the next row first.
	always_comb begin
		width_raw = EW'(cfg.image_width);
		if (width_raw < EW'(3)) begin
			width_eff = EW'(3);
		end else if (width_raw > EW'(MAX_WIDTH)) begin
			width_eff = EW'(MAX_WIDTH);
		end else begin
			width_eff = width_raw;
		end
		col_pre   = frame_start ? '0 : col_q;
		row_pre   = frame_start ? '0 : row_q;
		wrap_pre  = (EW'(col_pre) >= width_eff);
		col_cur   = wrap_pre ? '0 : col_pre;
		row_cur   = (wrap_pre && (row_pre != ROW_LIMIT)) ? row_pre + 1'b1 : row_pre;
		col_inc   = EW'(col_cur) + EW'(1);
		wrap_post = (col_inc >= width_eff);
		col_nxt   = wrap_post ? '0 : CW'(col_inc);
		row_nxt   = (wrap_post && (row_cur != ROW_LIMIT)) ? row_cur + 1'b1 : row_cur;
		emit      = (row_cur >= POS_W'(2)) && (EW'(col_cur) >= EW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1    <= red;
			g_s1    <= green;
			b_s1    <= blue;
			col_s1  <= col_cur;
			row_s1  <= row_cur - 1'b1;
			emit_s1 <= emit;
		end
		if (v_s1) begin
			pr_s2   <= PRW'(r_s1) * PRW'(LUMA_R);
			pg_s2   <= PRW'(g_s1) * PRW'(LUMA_G);
			pb_s2   <= PRW'(b_s1) * PRW'(LUMA_B);
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			emit_s2 <= emit_s1;
		end
	end

	always_comb begin
		gray_sum          = (PRW+1)'(pr_s2) + (PRW+1)'(pg_s2) + (PRW+1)'(pb_s2);
		push              = v_s2;
		push_col          = col_s2;
		push_item.gray    = gray_sum[PRW-1:WEIGHT_W];
		push_item.out_row = row_s2;
		push_item.emit    = emit_s2;
	end

endmodule

FILE: hdl/ggb_back.sv
// Back part: line stores, 3x3 window, weighted sum and saturation.
module ggb_back #(
	parameter int MAX_WIDTH = ggb_pkg::MAX_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ggb_pkg::ggb_cfg_t                        cfg,
	input  logic                                     head_valid,
	input  logic [$clog2(MAX_WIDTH)-1:0]             head_col,
	input  ggb_pkg::ggb_pix_t                        head_item,
	output logic                                     pop,
	input  logic [$clog2(ggb_pkg::OUT_DEPTH+1)-1:0]  out_count,
	output logic                                     res_push,
	output ggb_pkg::ggb_res_t                        res
);

	import ggb_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int OCW  = $clog2(OUT_DEPTH + 1);
	localparam int LW   = 2 * PIX_W;
	localparam int SW   = PIX_W + 2;
	localparam int PW   = SW + WEIGHT_W;
	localparam int PMW  = PIX_W + WEIGHT_W;
	localparam int ACCW = PW + 2;
	localparam int HIW  = ACCW - WEIGHT_W;

	// Each entry holds the upper row in the high byte and the middle row below.
	logic [LW-1:0]    ls_mem [MAX_WIDTH];
	logic [PIX_W-1:0] win_q [3][3];

	logic [OCW:0]     load;

	logic             v_s1;
	logic             byp_s1;
	logic [LW-1:0]    byp_data_s1;
	logic [LW-1:0]    rd_s1;
	logic [CW-1:0]    col_s1;
	ggb_pix_t         pix_s1;
	logic [LW-1:0]    line_eff;
	logic [PIX_W-1:0] up_eff;
	logic [PIX_W-1:0] mid_eff;

	logic             v_s2;
	logic             emit_s2;
	logic [POS_W-1:0] col_s2;
	logic [POS_W-1:0] row_s2;
	logic [SW-1:0]    corners;
	logic [SW-1:0]    edges;

	logic             v_s3;
	logic             emit_s3;
	logic [POS_W-1:0] col_s3;
	logic [POS_W-1:0] row_s3;
	logic [PW-1:0]    pc_s3;
	logic [PW-1:0]    pe_s3;
	logic [PMW-1:0]   pm_s3;
	logic [ACCW-1:0]  acc;
	logic [HIW-1:0]   acc_hi;

	always_comb begin
		load = (OCW+1)'(out_count) + (OCW+1)'(v_s1) + (OCW+1)'(v_s2) + (OCW+1)'(v_s3);
		pop  = head_valid && (load < (OCW+1)'(OUT_DEPTH));
	end

	// The read for the next word happens at the same edge as this word's write,
	// so a repeated column takes its line data from the bypass instead.
	always_comb begin
		line_eff = byp_s1 ? byp_data_s1 : rd_s1;
		up_eff   = line_eff[LW-1:PIX_W];
		mid_eff  = line_eff[PIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ls_mem[col_s1] <= {mid_eff, pix_s1.gray};
		end
		if (pop) begin
			rd_s1 <= ls_mem[head_col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else begin
			v_s1   <= pop;
			byp_s1 <= pop && v_s1 && (head_col == col_s1);
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			if (v_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k][0] <= win_q[k][1];
					win_q[k][1] <= win_q[k][2];
				end
				win_q[0][2] <= up_eff;
				win_q[1][2] <= mid_eff;
				win_q[2][2] <= pix_s1.gray;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			col_s1      <= head_col;
			pix_s1      <= head_item;
			byp_data_s1 <= {mid_eff, pix_s1.gray};
		end
		if (v_s1) begin
			emit_s2 <= pix_s1.emit;
			col_s2  <= POS_W'(col_s1 - 1'b1);
			row_s2  <= pix_s1.out_row;
		end
		if (v_s2) begin
			pc_s3   <= PW'(corners) * PW'(cfg.weight_corner);
			pe_s3   <= PW'(edges) * PW'(cfg.weight_edge);
			pm_s3   <= PMW'(win_q[1][1]) * PMW'(cfg.weight_center);
			emit_s3 <= emit_s2;
			col_s3  <= col_s2;
			row_s3  <= row_s2;
		end
	end

	always_comb begin
		corners = SW'(win_q[0][0]) + SW'(win_q[0][2]) + SW'(win_q[2][0]) + SW'(win_q[2][2]);
		edges   = SW'(win_q[0][1]) + SW'(win_q[1][0]) + SW'(win_q[1][2]) + SW'(win_q[2][1]);
	end

	always_comb begin
		acc            = ACCW'(pc_s3) + ACCW'(pe_s3) + ACCW'(pm_s3);
		acc_hi         = acc[ACCW-1:WEIGHT_W];
		res_push       = v_s3 && emit_s3;
		res.blurred    = (acc_hi > HIW'(255)) ? {PIX_W{1'b1}} : acc_hi[PIX_W-1:0];
		res.out_column = col_s3;
		res.out_row    = row_s3;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> v_s1)
		else $error("line bypass set without a word in the first stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (out_count != OCW'(OUT_DEPTH)))
		else $error("result produced with no room in the output queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue head taken while the queue is empty");

endmodule

FILE: hdl/gray_gaussian_blur_3x3.sv
// Gray 3x3 Gaussian blur over a raster RGB pixel stream, top level.
// Throughput: one pixel word per cycle; in_stall rises only when the middle queue, counting words in flight, fills.
// A result passes the front stages, the middle queue, the back stages and the output queue before it is offered.
// The rate is set by the line store, which takes one read and one write per pixel.
// Reset clears counts, window and queues and loads the default width and weights; the line
// stores are not cleared and hold no valid rows until written.
module gray_gaussian_blur_3x3 #(
	parameter int MAX_WIDTH = ggb_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ggb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ggb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ggb_pkg::PIX_W-1:0]         red,
	input  logic [ggb_pkg::PIX_W-1:0]         green,
	input  logic [ggb_pkg::PIX_W-1:0]         blue,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ggb_pkg::PIX_W-1:0]         blurred,
	output logic [ggb_pkg::POS_W-1:0]         out_column,
	output logic [ggb_pkg::POS_W-1:0]         out_row
);

	import ggb_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int ITEMW = $bits(ggb_pix_t);
	localparam int MIDW  = CW + ITEMW;
	localparam int RESW  = $bits(ggb_res_t);

	ggb_cfg_t cfg_q;

	logic                           push;
	logic [CW-1:0]                  push_col;
	ggb_pix_t                       push_item;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
	logic [MIDW-1:0]                mid_head;
	logic                           mid_valid;
	logic                           mid_pop;
	ggb_pix_t                       head_item;
	logic [CW-1:0]                  head_col;

	logic                           res_push;
	ggb_res_t                       res;
	logic [RESW-1:0]                out_word;
	ggb_res_t                       out_res;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
	logic                           out_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= IMAGE_WIDTH_RST;
			cfg_q.weight_center <= WEIGHT_CENTER_RST;
			cfg_q.weight_edge   <= WEIGHT_EDGE_RST;
			cfg_q.weight_corner <= WEIGHT_CORNER_RST;
		end else if (cfg_write) begin
			unique case (ggb_cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[WIDTH_CFG_W-1:0];
				CFG_WEIGHT_CENTER: cfg_q.weight_center <= cfg_data[WEIGHT_W-1:0];
				CFG_WEIGHT_EDGE:   cfg_q.weight_edge   <= cfg_data[WEIGHT_W-1:0];
				CFG_WEIGHT_CORNER: cfg_q.weight_corner <= cfg_data[WEIGHT_W-1:0];
			endcase
		end
	end

	ggb_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_start(frame_start),
		.q_count    (mid_count),
		.push       (push),
		.push_col   (push_col),
		.push_item  (push_item)
	);

	ggb_fifo #(
		.WIDTH(MIDW),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({push_col, push_item}),
		.pop    (mid_pop),
		.rd_data(mid_head),
		.valid  (mid_valid),
		.count  (mid_count)
	);

	assign head_col  = mid_head[MIDW-1:ITEMW];
	assign head_item = ggb_pix_t'(mid_head[ITEMW-1:0]);

	ggb_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(mid_valid),
		.head_col  (head_col),
		.head_item (head_item),
		.pop       (mid_pop),
		.out_count (out_count),
		.res_push  (res_push),
		.res       (res)
	);

	assign out_pop = out_valid && !out_stall;

	ggb_fifo #(
		.WIDTH(RESW),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wr_data(res),
		.pop    (out_pop),
		.rd_data(out_word),
		.valid  (out_valid),
		.count  (out_count)
	);

	assign out_res    = ggb_res_t'(out_word);
	assign blurred    = out_res.blurred;
	assign out_column = out_res.out_column;
	assign out_row    = out_res.out_row;

endmodule
